// ----- sv/dssi_pkg.sv -----
// ----------------------------------------------------------------------------
// dssi_pkg
// shared types, constants and gray decode for the dual ssi frame decoder
// ----------------------------------------------------------------------------
package dssi_pkg;

    localparam int DEF_MAX_FRAME_BITS = 18;
    localparam int SHORT_FRAME_BITS   = 16;
    localparam int POS_W              = 15;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [1:0] MODE_GRAY    = 2'd0;
    localparam logic [1:0] MODE_CHECKED = 2'd1;
    localparam logic [1:0] MODE_PARITY  = 2'd2;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [SHORT_FRAME_BITS-1:0] inv_a;
        logic [SHORT_FRAME_BITS-1:0] inv_b;
        logic [POS_W-1:0]            top_a;
        logic [POS_W-1:0]            top_b;
        logic                        line_ok;
        logic                        par_ok;
    } t_frame_rec;

    function automatic logic [SHORT_FRAME_BITS-1:0] gray_to_bin(
        input logic [SHORT_FRAME_BITS-1:0] g
    );
        logic [SHORT_FRAME_BITS-1:0] b;
        for (int i = 0; i < SHORT_FRAME_BITS; i++) begin
            b[i] = ^(g >> i);
        end
        return b;
    endfunction

endpackage

// ----- sv/dual_ssi_encoder_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// dual_ssi_encoder_frame_decoder
// Takes one 4-bit sample of two ssi encoder channels per cycle, msb first, and
// gives both 15-bit positions and an ok flag at the end of each frame. Frame
// length is 16 bits in gray and checked binary modes and MAX_FRAME_BITS in
// parity mode. A sample is accepted every cycle; the input stalls only when
// the two-word queue between the frame tracker and the decoder is full. The
// result word passes through the queue and is then held in the output register.
// ----------------------------------------------------------------------------
module dual_ssi_encoder_frame_decoder
    import dssi_pkg::*;
#(
    parameter int MAX_FRAME_BITS = DEF_MAX_FRAME_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [3:0]       i_sample_lines,
    input  logic             i_frame_start,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [POS_W-1:0] o_position_a,
    output logic [POS_W-1:0] o_position_b,
    output logic             o_frame_ok
);

    t_frame_rec push_rec, pop_rec;
    logic       push, pop, q_full, q_valid;

    dssi_front #(
        .MAX_FRAME_BITS(MAX_FRAME_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_sample_lines (i_sample_lines),
        .i_frame_start  (i_frame_start),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_rec          (push_rec)
    );

    dssi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_rec   (pop_rec)
    );

    dssi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_rec        (pop_rec),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_position_a (o_position_a),
        .o_position_b (o_position_b),
        .o_frame_ok   (o_frame_ok)
    );

endmodule

// ----- sv/dssi_front.sv -----
// ----------------------------------------------------------------------------
// dssi_front
// takes samples, tracks the frame, shifts in the lines and queues frame words
// ----------------------------------------------------------------------------
module dssi_front
    import dssi_pkg::*;
#(
    parameter int MAX_FRAME_BITS = DEF_MAX_FRAME_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_sample_lines,
    input  logic       i_frame_start,
    input  logic       i_q_full,
    output logic       o_push,
    output t_frame_rec o_rec
);

    localparam int CNT_W = $clog2(MAX_FRAME_BITS + 1);

    logic [CNT_W-1:0]          r_cnt, n_cnt, base_cnt, frame_len;
    logic [MAX_FRAME_BITS-1:0] r_dir_a, r_dir_b, r_inv_a, r_inv_b;
    logic [MAX_FRAME_BITS-1:0] n_dir_a, n_dir_b, n_inv_a, n_inv_b;
    logic [MAX_FRAME_BITS-1:0] b_dir_a, b_dir_b, b_inv_a, b_inv_b;
    logic                      r_par_a, r_par_b, n_par_a, n_par_b;
    logic [1:0]                r_mode;
    logic                      accept, active, take, done;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign active  = i_frame_start || (r_cnt != '0);
    assign take    = accept && active;

    always_comb begin
        base_cnt = i_frame_start ? '0 : r_cnt;
        b_dir_a  = i_frame_start ? '0 : r_dir_a;
        b_dir_b  = i_frame_start ? '0 : r_dir_b;
        b_inv_a  = i_frame_start ? '0 : r_inv_a;
        b_inv_b  = i_frame_start ? '0 : r_inv_b;
        n_cnt    = base_cnt + CNT_W'(1);
        n_dir_a  = {b_dir_a[MAX_FRAME_BITS-2:0], i_sample_lines[0]};
        n_inv_a  = {b_inv_a[MAX_FRAME_BITS-2:0], ~i_sample_lines[1]};
        n_dir_b  = {b_dir_b[MAX_FRAME_BITS-2:0], i_sample_lines[2]};
        n_inv_b  = {b_inv_b[MAX_FRAME_BITS-2:0], ~i_sample_lines[3]};
        n_par_a  = (i_frame_start ? 1'b0 : r_par_a) ^ i_sample_lines[0];
        n_par_b  = (i_frame_start ? 1'b0 : r_par_b) ^ i_sample_lines[2];
        frame_len = (r_mode == MODE_PARITY) ? CNT_W'(MAX_FRAME_BITS)
                                            : CNT_W'(SHORT_FRAME_BITS);
        done = take && (n_cnt >= frame_len);
    end

    assign o_push        = done;
    assign o_rec.mode    = r_mode;
    assign o_rec.inv_a   = n_inv_a[SHORT_FRAME_BITS-1:0];
    assign o_rec.inv_b   = n_inv_b[SHORT_FRAME_BITS-1:0];
    assign o_rec.top_a   = n_dir_a[MAX_FRAME_BITS-1 -: POS_W];
    assign o_rec.top_b   = n_dir_b[MAX_FRAME_BITS-1 -: POS_W];
    assign o_rec.line_ok = (n_inv_a[SHORT_FRAME_BITS-1:0] == n_dir_a[SHORT_FRAME_BITS-1:0])
                        && (n_inv_b[SHORT_FRAME_BITS-1:0] == n_dir_b[SHORT_FRAME_BITS-1:0]);
    assign o_rec.par_ok  = !n_par_a && !n_par_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_mode <= MODE_GRAY;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (take) begin
                r_cnt <= done ? '0 : n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_dir_a <= n_dir_a;
            r_dir_b <= n_dir_b;
            r_inv_a <= n_inv_a;
            r_inv_b <= n_inv_b;
            r_par_a <= n_par_a;
            r_par_b <= n_par_b;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_FRAME_BITS))
        else $error("bit count beyond frame length");

    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_cnt == '0)
        else $error("frame not closed after push");

endmodule

// ----- sv/dssi_queue.sv -----
// ----------------------------------------------------------------------------
// dssi_queue
// short queue of finished frame words between front and back
// ----------------------------------------------------------------------------
module dssi_queue
    import dssi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    output logic       o_full,
    output logic       o_valid,
    input  logic       i_pop,
    output t_frame_rec o_rec
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ----- sv/dssi_back.sv -----
// ----------------------------------------------------------------------------
// dssi_back
// decodes a queued frame word per mode and holds the result word
// ----------------------------------------------------------------------------
module dssi_back
    import dssi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_frame_rec       i_rec,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [POS_W-1:0] o_position_a,
    output logic [POS_W-1:0] o_position_b,
    output logic             o_frame_ok
);

    logic                        r_valid, r_ok;
    logic [POS_W-1:0]            r_pos_a, r_pos_b;
    logic [POS_W-1:0]            n_pos_a, n_pos_b;
    logic                        n_ok;
    logic [SHORT_FRAME_BITS-1:0] bin_a, bin_b;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        bin_a = gray_to_bin(i_rec.inv_a);
        bin_b = gray_to_bin(i_rec.inv_b);
        unique case (i_rec.mode)
            MODE_CHECKED: begin
                n_ok    = i_rec.line_ok && i_rec.par_ok;
                n_pos_a = i_rec.inv_a[SHORT_FRAME_BITS-1 -: POS_W];
                n_pos_b = i_rec.inv_b[SHORT_FRAME_BITS-1 -: POS_W];
            end
            MODE_PARITY: begin
                n_ok    = i_rec.par_ok;
                n_pos_a = i_rec.top_a;
                n_pos_b = i_rec.top_b;
            end
            default: begin
                n_ok    = 1'b1;
                n_pos_a = bin_a[SHORT_FRAME_BITS-1 -: POS_W];
                n_pos_b = bin_b[SHORT_FRAME_BITS-1 -: POS_W];
            end
        endcase
        if (!n_ok) begin
            n_pos_a = '0;
            n_pos_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok    <= n_ok;
            r_pos_a <= n_pos_a;
            r_pos_b <= n_pos_b;
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_ok   = r_ok;
    assign o_position_a = r_pos_a;
    assign o_position_b = r_pos_b;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_ok) |-> (r_pos_a == '0 && r_pos_b == '0))
        else $error("failed frame with nonzero position");

endmodule
